FILE: rtl/core/buffer_slot_pool_allocator_top_defines.svh
// Assertion helpers shared by the pool allocator RTL.
`ifndef BUFFER_SLOT_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define BUFFER_SLOT_POOL_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/bspa_pkg.sv
package bspa_pkg;

  localparam int POOL_DEPTH = 64;
  localparam int WORD_W     = 8;
  localparam int ROWS       = (POOL_DEPTH + WORD_W - 1) / WORD_W;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int CNT_W      = 7;
  localparam int SLOT_W     = 6;
  localparam int PADDR_W    = 3;
  localparam int OUT_W      = 24;

  // Division by five as a multiply by 1639/8192, exact for the 7-bit sizes used here.
  localparam int DIV5_MUL   = 1639;
  localparam int DIV5_SHIFT = 13;
  localparam int PROD_W     = CNT_W + 11;

  localparam logic [CNT_W-1:0] POOL_SIZE_RST = 7'd64;
  localparam int REG_POOL_SIZE = 0;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EXHAUSTED   = 2'd1,
    ST_DOUBLE      = 2'd2,
    ST_NOT_IN_POOL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_WB   = 2'b10
  } fsm_e;

  function automatic logic [CNT_W-1:0] active_size(input logic [CNT_W-1:0] pool);
    return (int'(pool) > POOL_DEPTH) ? CNT_W'(POOL_DEPTH) : pool;
  endfunction

  function automatic logic [CNT_W-1:0] div5(input logic [CNT_W-1:0] size);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(size) * PROD_W'(DIV5_MUL);
    return CNT_W'(prod >> DIV5_SHIFT);
  endfunction

  // Rows that hold at least one active slot.
  function automatic logic [ROWS-1:0] row_flags(input logic [CNT_W-1:0] size);
    logic [ROWS-1:0] f;
    for (int r = 0; r < ROWS; r++) begin
      f[r] = (r * WORD_W < int'(size));
    end
    return f;
  endfunction

  // Active slots within one row.
  function automatic logic [WORD_W-1:0] row_mask(input logic [ROW_W-1:0] row,
                                                 input logic [CNT_W-1:0] size);
    logic [WORD_W-1:0] m;
    for (int j = 0; j < WORD_W; j++) begin
      m[j] = (int'(row) * WORD_W + j < int'(size));
    end
    return m;
  endfunction

endpackage

FILE: rtl/core/buffer_slot_pool_allocator_top.sv
// Slot pool allocator with a free bitmap.
// Input stream: s_axis_tuser_i is the mode (0 acquire, 1 release), s_axis_tdata_i[5:0]
// the slot to release. Each input beat yields exactly one output beat carrying status,
// granted slot, free and used counts, and the healthy and has-free flags.
// The bitmap lives in a synchronous memory of 8-bit rows; a flag register per row marks
// rows holding a free active slot, so an acquire picks its row by a priority encode.
// The row is read when a beat is accepted; in the write-back state the block then
// modifies the row, writes it back and loads the output register. This read-modify-write
// on the single memory port means a new beat is accepted only after the last is written back.
// The output register lets a new beat be accepted while a result waits; if the result
// is still not taken when the next one is ready, the block holds in its write-back
// state and deasserts s_axis_tready_o until the output stage frees up.
// Reset (rst_ni low, asynchronous) sets the pool size to 64 with every slot free; row
// valid bits make unwritten rows read as all free, so no clearing pass is needed.
// Writing pool_size (APB, address 0) frees every slot and clears the used count; the
// user must write it only while the block is idle, and the block does not enforce this.
`include "buffer_slot_pool_allocator_top_defines.svh"

module buffer_slot_pool_allocator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,  // [5:0] slot_index
  input  logic                           s_axis_tuser_i,  // [0] mode
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [1:0] status, [7:2] granted_slot, [14:8] free_count, [21:15] used_count,
  // [22] healthy, [23] has_free
  output logic [bspa_pkg::OUT_W-1:0]     m_axis_tdata_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bspa_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import bspa_pkg::*;

  fsm_e state_q, state_d;

  logic [CNT_W-1:0] pool_size_q, size_q, div5_q, free_q, used_q;
  logic [ROWS-1:0]  row_flag_q, row_valid_q;

  logic              mode_q;
  logic [SLOT_W-1:0] idx_q;
  logic [ROW_W-1:0]  row_q;
  logic              exh_q;

  logic [WORD_W-1:0] mem [ROWS];
  logic [WORD_W-1:0] rdata_q;

  logic             m_valid_q;
  logic [OUT_W-1:0] m_data_q;

  logic              accept, do_wb, cfg_we, reg_sel;
  logic [CNT_W-1:0]  pool_new, size_new;
  logic [ROW_W-1:0]  acq_row, rel_row, rd_row;
  logic              any_free;

  logic [WORD_W-1:0] word, mask, avail, wdata;
  logic [BIT_W-1:0]  bsel, bit_rel;
  logic              mem_we, flag_n;
  status_e           status;
  logic [SLOT_W-1:0] granted;
  logic [CNT_W-1:0]  free_n, used_n;
  logic              healthy, has_free;

  // Handshakes.
  assign s_axis_tready_o = (state_q == FSM_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign do_wb           = (state_q == FSM_WB) & (~m_valid_q | m_axis_tready_i);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Configuration port.
  assign pready   = 1'b1;
  assign reg_sel  = (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_POOL_SIZE));
  assign cfg_we   = psel & penable & pwrite & reg_sel;
  assign pool_new = pwdata[CNT_W-1:0];
  assign size_new = active_size(pool_new);
  assign prdata   = reg_sel ? 32'(pool_size_q) : 32'd0;

  // Row choice at accept time.
  always_comb begin
    acq_row = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (row_flag_q[r]) acq_row = ROW_W'(r);
    end
  end

  assign any_free = |row_flag_q;
  assign rel_row  = ROW_W'(s_axis_tdata_i[SLOT_W-1:0] >> BIT_W);
  assign rd_row   = s_axis_tuser_i ? rel_row : acq_row;

  always_ff @(posedge clk_i) begin
    if (accept) rdata_q <= mem[rd_row];
    if (mem_we) mem[row_q] <= wdata;
  end

  // Modify step on the row read when the beat was accepted.
  assign word    = row_valid_q[row_q] ? rdata_q : '1;
  assign mask    = row_mask(row_q, size_q);
  assign avail   = word & mask;
  assign bit_rel = idx_q[BIT_W-1:0];

  always_comb begin
    bsel = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (avail[j]) bsel = BIT_W'(j);
    end
  end

  always_comb begin
    status  = ST_OK;
    granted = '0;
    wdata   = word;
    mem_we  = 1'b0;
    flag_n  = row_flag_q[row_q];
    free_n  = free_q;
    used_n  = used_q;
    if (!mode_q) begin
      if (exh_q) begin
        status = ST_EXHAUSTED;
      end else begin
        wdata   = word & ~(WORD_W'(1) << bsel);
        mem_we  = do_wb;
        flag_n  = |(wdata & mask);
        granted = SLOT_W'(int'(row_q) * WORD_W + int'(bsel));
        free_n  = free_q - CNT_W'(1);
        used_n  = used_q + CNT_W'(1);
      end
    end else begin
      if ({1'b0, idx_q} >= size_q) begin
        status = ST_NOT_IN_POOL;
      end else if (word[bit_rel]) begin
        status = ST_DOUBLE;
      end else begin
        wdata  = word | (WORD_W'(1) << bit_rel);
        mem_we = do_wb;
        flag_n = 1'b1;
        free_n = free_q + CNT_W'(1);
        used_n = used_q - CNT_W'(1);
      end
    end
  end

  assign healthy  = (free_n >= div5_q);
  assign has_free = (free_n != '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: if (accept) state_d = FSM_WB;
      FSM_WB:   if (do_wb) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      pool_size_q <= POOL_SIZE_RST;
      size_q      <= active_size(POOL_SIZE_RST);
      div5_q      <= div5(active_size(POOL_SIZE_RST));
      free_q      <= active_size(POOL_SIZE_RST);
      used_q      <= '0;
      row_flag_q  <= row_flags(active_size(POOL_SIZE_RST));
      row_valid_q <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        pool_size_q <= pool_new;
        size_q      <= size_new;
        div5_q      <= div5(size_new);
        free_q      <= size_new;
        used_q      <= '0;
        row_flag_q  <= row_flags(size_new);
        row_valid_q <= '0;
      end else if (do_wb) begin
        free_q <= free_n;
        used_q <= used_n;
        if (mem_we) begin
          row_flag_q[row_q]  <= flag_n;
          row_valid_q[row_q] <= 1'b1;
        end
      end
      if (do_wb) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= s_axis_tuser_i;
      idx_q  <= s_axis_tdata_i[SLOT_W-1:0];
      row_q  <= rd_row;
      exh_q  <= ~any_free;
    end
    if (do_wb) begin
      m_data_q <= {has_free, healthy, used_n, free_n, granted, status};
    end
  end

  `BSPA_ASSERT_NOW(a_count_sum, 1'b1, 8'(free_q) + 8'(used_q) == 8'(size_q), "counts disagree")
  `BSPA_ASSERT_NOW(a_flags_match, 1'b1, (free_q != '0) == (|row_flag_q), "row flags disagree")
  `BSPA_ASSERT_NEXT(a_accept_wb, accept, state_q == FSM_WB, "no write-back after accept")
  `BSPA_ASSERT_NEXT(a_exhausted, do_wb && !mode_q && exh_q, free_q == '0, "false exhaustion")

endmodule
